@@ sv/bcc_pkg.sv @@
// Shared types, constants and helpers for the button click classifier.
package bcc_pkg;

   // Width of the hold, release gap and debounce tick counters
   localparam int TIMER_WIDTH = 16;
   // Width of each configuration register
   localparam int CSR_WIDTH   = 16;
   // Width used when a counter is compared against a register
   localparam int CMP_WIDTH   = (TIMER_WIDTH > CSR_WIDTH) ? TIMER_WIDTH : CSR_WIDTH;
   localparam int CSR_IDX_W   = 3;
   localparam int TALLY_W     = 3;

   typedef logic [TIMER_WIDTH-1:0] timer_type;
   typedef logic [CSR_WIDTH-1:0]   csr_data_type;
   typedef logic [TALLY_W-1:0]     tally_type;

   // Register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEBOUNCE    = 3'd0,
      CSR_SHORT_CLICK = 3'd1,
      CSR_LONG_PRESS  = 3'd2,
      CSR_VERY_LONG   = 3'd3,
      CSR_CLICK_GAP   = 3'd4
   } csr_index_type;

   // Result codes
   typedef enum logic [2:0] {
      EV_NONE      = 3'd0,
      EV_SINGLE    = 3'd1,
      EV_DOUBLE    = 3'd2,
      EV_TRIPLE    = 3'd3,
      EV_LONG      = 3'd4,
      EV_VERY_LONG = 3'd5
   } event_code_type;

   // Register reset values
   localparam csr_data_type DEBOUNCE_RST    = 16'd50;
   localparam csr_data_type SHORT_CLICK_RST = 16'd500;
   localparam csr_data_type LONG_PRESS_RST  = 16'd3000;
   localparam csr_data_type VERY_LONG_RST   = 16'd10000;
   localparam csr_data_type CLICK_GAP_RST   = 16'd400;

   // Thresholds as seen by the classifier
   typedef struct packed {
      csr_data_type settle_len;
      csr_data_type short_click_max_ms;
      csr_data_type long_hold_len;
      csr_data_type vlong_hold_len;
      csr_data_type multi_click_gap_ms;
   } cfg_type;

   // Advance a tick counter, stopping at all ones
   function automatic timer_type sat_inc(input timer_type v);
      return (&v) ? v : timer_type'(v + 1'b1);
   endfunction

   function automatic logic [CMP_WIDTH-1:0] widen_timer(input timer_type v);
      return CMP_WIDTH'(v);
   endfunction

   function automatic logic [CMP_WIDTH-1:0] widen_csr(input csr_data_type v);
      return CMP_WIDTH'(v);
   endfunction

endpackage

@@ sv/bcc_csr.sv @@
// Configuration register bank of the button click classifier.
module bcc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             we,
   input  logic [bcc_pkg::CSR_IDX_W-1:0]    index,
   input  logic [bcc_pkg::CSR_WIDTH-1:0]    wdata,
   output bcc_pkg::cfg_type                 cfg
);
   import bcc_pkg::*;

   cfg_type cfg_ff;

   // Write the addressed register; drop writes beyond the list
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.settle_len         <= DEBOUNCE_RST;
         cfg_ff.short_click_max_ms <= SHORT_CLICK_RST;
         cfg_ff.long_hold_len      <= LONG_PRESS_RST;
         cfg_ff.vlong_hold_len     <= VERY_LONG_RST;
         cfg_ff.multi_click_gap_ms <= CLICK_GAP_RST;
      end else if (we) begin
         case (index)
            CSR_DEBOUNCE:    cfg_ff.settle_len         <= wdata;
            CSR_SHORT_CLICK: cfg_ff.short_click_max_ms <= wdata;
            CSR_LONG_PRESS:  cfg_ff.long_hold_len      <= wdata;
            CSR_VERY_LONG:   cfg_ff.vlong_hold_len     <= wdata;
            CSR_CLICK_GAP:   cfg_ff.multi_click_gap_ms <= wdata;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ sv/bcc_core.sv @@
// Press state and classification logic: one tick per step.
module bcc_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic                      level,
   input  bcc_pkg::cfg_type          cfg,
   output bcc_pkg::event_code_type   ev_code
);
   import bcc_pkg::*;

   logic      prev_level_ff, prev_level_in;
   timer_type stable_ff,     stable_in;
   logic      held_ff,       held_in;
   timer_type hold_ff,       hold_in;
   logic      vlong_done_ff, vlong_done_in;
   tally_type tally_ff,      tally_in;
   timer_type gap_ff,        gap_in;
   logic      awaiting_ff,   awaiting_in;

   logic      debounced;
   logic      pressed;

   // Next state and result for the current tick
   always_comb begin
      hold_in       = sat_inc(hold_ff);
      gap_in        = sat_inc(gap_ff);
      stable_in     = (level != prev_level_ff) ? '0 : sat_inc(stable_ff);
      prev_level_in = level;
      held_in       = held_ff;
      vlong_done_in = vlong_done_ff;
      tally_in      = tally_ff;
      awaiting_in   = awaiting_ff;
      ev_code       = EV_NONE;

      debounced = widen_timer(stable_in) >= widen_csr(cfg.settle_len);
      pressed   = !level;

      if (debounced) begin
         if (pressed && !held_ff) begin
            // Start of a debounced press
            held_in       = 1'b1;
            hold_in       = '0;
            vlong_done_in = 1'b0;
         end else if (pressed) begin
            // Fire very long press once while held
            if (widen_timer(hold_in) >= widen_csr(cfg.vlong_hold_len) &&
                !vlong_done_ff) begin
               vlong_done_in = 1'b1;
               tally_in      = '0;
               awaiting_in   = 1'b0;
               ev_code       = EV_VERY_LONG;
            end
         end else if (held_ff) begin
            // Release: long press, click, or nothing
            held_in = 1'b0;
            if (!vlong_done_ff) begin
               if (widen_timer(hold_in) >= widen_csr(cfg.long_hold_len)) begin
                  tally_in    = '0;
                  awaiting_in = 1'b0;
                  ev_code     = EV_LONG;
               end else if (widen_timer(hold_in) < widen_csr(cfg.short_click_max_ms)) begin
                  if (!(&tally_ff))
                     tally_in = tally_type'(tally_ff + 1'b1);
                  gap_in      = '0;
                  awaiting_in = 1'b1;
               end
            end
         end else if (awaiting_ff &&
                      widen_timer(gap_in) > widen_csr(cfg.multi_click_gap_ms)) begin
            // Report the counted clicks after the gap
            awaiting_in = 1'b0;
            tally_in    = '0;
            case (tally_ff)
               3'd2:    ev_code = EV_DOUBLE;
               3'd3:    ev_code = EV_TRIPLE;
               default: ev_code = EV_SINGLE;
            endcase
         end
      end
   end

   // Commit state when a tick is consumed
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_level_ff <= 1'b1;
         stable_ff     <= '0;
         held_ff       <= 1'b0;
         hold_ff       <= '0;
         vlong_done_ff <= 1'b0;
         tally_ff      <= '0;
         gap_ff        <= '0;
         awaiting_ff   <= 1'b0;
      end else if (step) begin
         prev_level_ff <= prev_level_in;
         stable_ff     <= stable_in;
         held_ff       <= held_in;
         hold_ff       <= hold_in;
         vlong_done_ff <= vlong_done_in;
         tally_ff      <= tally_in;
         gap_ff        <= gap_in;
         awaiting_ff   <= awaiting_in;
      end
   end

endmodule

@@ sv/button_click_classifier.sv @@
// Top level of the button click classifier: input stage, register bank, core and result register.
//
//   channel   direction  payload
//   req_      in         tdata[0] button_level
//   rsp_      out        tdata[2:0] event_code
//   csr_      in         write: csr_index, csr_wdata[15:0]
//
// Each tick item yields one result item. An item is held in the input register
// and then moves into the result register; one item per cycle is sustained
// while results are taken, as the core updates its state on each accepted tick.
// Reset is synchronous and active high; it clears the press state and loads
// the register defaults. A stalled result holds the input stage, and the
// input stage still takes a new item whenever its content moves on.
module button_click_classifier (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,   // [0] button_level
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [7:0]                         rsp_tdata,   // [2:0] event_code
   input  logic                               csr_we,
   input  logic [bcc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bcc_pkg::CSR_WIDTH-1:0]      csr_wdata
);
   import bcc_pkg::*;

   cfg_type        cfg;
   event_code_type ev_code;

   logic           in_valid_ff;
   logic           in_level_ff;
   logic           out_valid_ff;
   event_code_type out_code_ff;
   logic           advance;

   // Move the staged item on when the result register is free or drained
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   bcc_csr u_csr (
      .clock (clock),
      .reset (reset),
      .we    (csr_we),
      .index (csr_index),
      .wdata (csr_wdata),
      .cfg   (cfg)
   );

   bcc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .level   (in_level_ff),
      .cfg     (cfg),
      .ev_code (ev_code)
   );

   // Input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_level_ff <= req_tdata[0];
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_code_ff <= ev_code;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b0, out_code_ff};

endmodule

@@ bench/tb.sv @@
// Testbench for the button click classifier: tick stream in, event stream out.
`timescale 1ns / 100ps

module tb;
   import bcc_pkg::*;

   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int ITEMS_PER_MODE  = 60;
   localparam int SPAN_CAP        = 24;
   // Indexes past the last register; writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_FIRST = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LAST  = 3'd7;

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata  = '0;   // [0] button_level
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;         // [2:0] event_code
   logic                 csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   csr_data_type         csr_wdata  = '0;

   button_click_classifier i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Levels waiting to be sent and events waiting to come back
   logic           pend_levels[$];
   event_code_type expected_events[$];

   int   errors        = 0;
   int   quiet_cycles  = 0;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   logic send_hold     = 1'b0;
   logic rx_block      = 1'b0;
   int   rx_block_cnt  = 0;
   logic in_took       = 1'b0;
   int   phase_items   = 0;

   // Threshold mirror and press tracking state
   cfg_type   th = '{DEBOUNCE_RST, SHORT_CLICK_RST, LONG_PRESS_RST,
                     VERY_LONG_RST, CLICK_GAP_RST};
   logic      last_level      = 1'b1;
   timer_type steady_len      = '0;
   logic      holding         = 1'b0;
   timer_type press_len       = '0;
   logic      very_long_fired = 1'b0;
   tally_type clicks          = '0;
   timer_type gap_len         = '0;
   logic      waiting_clicks  = 1'b0;

   function automatic timer_type tick_up(input timer_type v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   // Advance the press state by one tick and return the event it raises
   function automatic event_code_type tick_classify(input logic level);
      event_code_type ev;
      ev = EV_NONE;
      press_len = tick_up(press_len);
      gap_len   = tick_up(gap_len);
      steady_len = (level != last_level) ? timer_type'(0) : tick_up(steady_len);
      last_level = level;
      if (steady_len >= th.settle_len) begin
         if (!level && !holding) begin
            holding = 1'b1;
            press_len = '0;
            very_long_fired = 1'b0;
         end else if (!level) begin
            if (press_len >= th.vlong_hold_len && !very_long_fired) begin
               very_long_fired = 1'b1;
               clicks = '0;
               waiting_clicks = 1'b0;
               ev = EV_VERY_LONG;
            end
         end else if (holding) begin
            holding = 1'b0;
            if (!very_long_fired) begin
               if (press_len >= th.long_hold_len) begin
                  clicks = '0;
                  waiting_clicks = 1'b0;
                  ev = EV_LONG;
               end else if (press_len < th.short_click_max_ms) begin
                  if (clicks != 3'd7) clicks = clicks + 1'b1;
                  gap_len = '0;
                  waiting_clicks = 1'b1;
               end
            end
         end else if (waiting_clicks && gap_len > th.multi_click_gap_ms) begin
            case (clicks)
               3'd2:    ev = EV_DOUBLE;
               3'd3:    ev = EV_TRIPLE;
               default: ev = EV_SINGLE;
            endcase
            waiting_clicks = 1'b0;
            clicks = '0;
         end
      end
      return ev;
   endfunction

   // Drive tick items; hold the offered item until it is taken
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || in_took) begin
         if (pend_levels.size() != 0 && !send_hold &&
             $urandom_range(0, 99) >= send_idle_pct) begin
            req_tdata  <= {7'b0, pend_levels.pop_front()};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Drive result ready: random stalls, or a long hold-off when asked
   always @(negedge clock) begin
      if (!rx_block) rx_block_cnt = 0;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rx_block && rx_block_cnt < HOLD_OFF_CYCLES) begin
         rsp_tready <= 1'b0;
         rx_block_cnt = rx_block_cnt + 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Predict on accepted ticks, check accepted events, watch for a hang
   always @(posedge clock) begin : monitor
      event_code_type want;
      logic [2:0]     got;
      if (reset) begin
         in_took <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         in_took <= req_tvalid && req_tready;
         if (req_tvalid && req_tready)
            expected_events.push_back(tick_classify(req_tdata[0]));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[2:0];
            if (expected_events.size() == 0) begin
               $display("%0t: unexpected event_code %0d, expected none", $time, got);
               errors++;
            end else begin
               want = expected_events.pop_front();
               if (got !== want) begin
                  $display("%0t: event_code expected %0d got %0d", $time, want, got);
                  errors++;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("TB_ERROR");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   function automatic int clip(input int v);
      return (v > SPAN_CAP) ? SPAN_CAP : v;
   endfunction

   task automatic add_run(input logic level, input int n);
      repeat (n) pend_levels.push_back(level);
      phase_items += n;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input csr_data_type val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_DEBOUNCE:    th.settle_len         = val;
         CSR_SHORT_CLICK: th.short_click_max_ms = val;
         CSR_LONG_PRESS:  th.long_hold_len      = val;
         CSR_VERY_LONG:   th.vlong_hold_len     = val;
         CSR_CLICK_GAP:   th.multi_click_gap_ms = val;
         default: ;
      endcase
   endtask

   task automatic write_thresholds(input cfg_type c);
      write_reg(CSR_DEBOUNCE,    c.settle_len);
      write_reg(CSR_SHORT_CLICK, c.short_click_max_ms);
      write_reg(CSR_LONG_PRESS,  c.long_hold_len);
      write_reg(CSR_VERY_LONG,   c.vlong_hold_len);
      write_reg(CSR_CLICK_GAP,   c.multi_click_gap_ms);
   endtask

   // Wait until nothing is queued, offered or outstanding, then let the pipe settle
   task automatic wait_idle();
      do @(negedge clock);
      while (pend_levels.size() != 0 || req_tvalid || expected_events.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // One press or a burst of short bounces, then a release, with lengths spread around the thresholds
   task automatic add_episode();
      int d;
      int s;
      int mid;
      logic lvl;
      d = th.settle_len;
      s = clip(th.short_click_max_ms);
      mid = (th.long_hold_len > th.short_click_max_ms) ?
            clip(th.long_hold_len - th.short_click_max_ms) : 0;
      case ($urandom_range(0, 11))
         0, 1, 2, 3, 4: add_run(1'b0, d + 1 + $urandom_range(0, s));
         5: add_run(1'b0, d + 1 + s + $urandom_range(0, mid));
         6: add_run(1'b0, d + 1 + clip(th.long_hold_len) + $urandom_range(0, 3));
         7: add_run(1'b0, d + 1 + clip(th.vlong_hold_len) + $urandom_range(0, 3));
         8: begin
            lvl = 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 4)) begin
               add_run(lvl, $urandom_range(1, d + 1));
               lvl = !lvl;
            end
         end
         default: repeat ($urandom_range(1, 6)) add_run(1'($urandom_range(0, 1)), 1);
      endcase
      if ($urandom_range(0, 2) == 0)
         add_run(1'b1, d + 1 + clip(th.multi_click_gap_ms) + $urandom_range(1, 4));
      else
         add_run(1'b1, d + 1 + $urandom_range(0, clip(th.multi_click_gap_ms)));
   endtask

   initial begin
      cfg_type plan[5];
      int      idle_pct[4];
      int      stall_pct[4];
      plan[0] = '{16'd2, 16'd6,     16'd12,    16'd20,    16'd5};
      plan[1] = '{16'd0, 16'd4,     16'd8,     16'd14,    16'd3};
      plan[2] = '{16'd3, 16'd10,    16'd10,    16'd16,    16'd0};
      plan[3] = '{16'd1, 16'd0,     16'd0,     16'd0,     16'd2};
      plan[4] = '{16'd1, 16'hFFFF,  16'hFFFF,  16'hFFFF,  16'd8};
      idle_pct  = '{0, 81, 0, 6};
      stall_pct = '{0, 0, 81, 6};

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Defaults after reset: a few ticks deep inside the debounce window
      recv_stall_pct = 10;
      add_run(1'b0, 1);
      add_run(1'b1, 1);
      add_run(1'b0, 1);
      add_run(1'b1, 1);
      wait_idle();

      // Directed presses with tiny thresholds; spare indexes must not alias
      write_thresholds('{16'd0, 16'd2, 16'd4, 16'd6, 16'd1});
      for (int k = CSR_SPARE_FIRST; k <= CSR_SPARE_LAST; k++)
         write_reg(CSR_IDX_W'(k), 16'hFFFF);
      add_run(1'b0, 1);   // single click
      add_run(1'b1, 3);
      repeat (3) begin    // triple click
         add_run(1'b0, 1);
         add_run(1'b1, 1);
      end
      add_run(1'b1, 2);
      add_run(1'b0, 3);   // middle-length hold, no event
      add_run(1'b1, 1);
      add_run(1'b0, 5);   // long press on release
      add_run(1'b1, 1);
      add_run(1'b0, 7);   // very long press while held, silent release
      add_run(1'b1, 1);
      wait_idle();

      // Random press streams under each threshold set and each idle pattern
      for (int p = 0; p < 5; p++) begin
         write_thresholds(plan[p]);
         for (int m = 0; m < 4; m++) begin
            send_idle_pct  = idle_pct[m];
            recv_stall_pct = stall_pct[m];
            phase_items = 0;
            while (phase_items < ITEMS_PER_MODE) add_episode();
            if (p == 0 && m == 0) begin
               // Back-pressure: block results while ticks keep coming
               rx_block = 1'b1;
               wait (rx_block_cnt == HOLD_OFF_CYCLES);
               rx_block = 1'b0;
            end
            if (p == 1 && m == 0) begin
               // Pause the sender until every outstanding event is back
               while (pend_levels.size() > ITEMS_PER_MODE / 2) @(negedge clock);
               send_hold = 1'b1;
               do @(negedge clock);
               while (req_tvalid || expected_events.size() != 0);
               send_hold = 1'b0;
            end
            while (pend_levels.size() != 0) @(negedge clock);
         end
         wait_idle();
      end

      // Widest debounce window: short runs never get past it
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_reg(CSR_DEBOUNCE, 16'hFFFF);
      write_reg(CSR_VERY_LONG, 16'd0);
      write_reg(CSR_CLICK_GAP, 16'hFFFF);
      add_run(1'b1, 3);
      add_run(1'b0, 8);
      add_run(1'b1, 4);
      wait_idle();

      repeat (20) @(posedge clock);
      if (errors == 0 && expected_events.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
